// ----- rtl/core/bacrms_pkg.sv -----
// Shared widths, register indexes and state type of the batch AC RMS meter.
package bacrms_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int COUNT_BITS  = 16;

   localparam int MV_BITS       = 12;
   localparam int CH_BITS       = 4;
   localparam int LEN_BITS      = 16;
   localparam int RMS_BITS      = 12;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS    = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int PROD_BITS  = SQ_BITS + COUNT_BITS;
   localparam int RAD_BITS   = PROD_BITS + 2;
   localparam int ROOT_BITS  = RAD_BITS / 2;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int NUM_BITS   = ROOT_BITS + 1;
   localparam int RDIV_BITS  = COUNT_BITS + 2;
   localparam int CMP_BITS   = COUNT_BITS + LEN_BITS;
   localparam int MSTEP_BITS = $clog2(SUM_BITS + 1);
   localparam int STEP_BITS  = $clog2(NUM_BITS + 1);

   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(1000);
   localparam logic [CH_BITS-1:0]  CH_RESET  = '0;

   localparam logic REG_BATCH_LENGTH = 1'b0;
   localparam logic REG_EXP_CHANNEL  = 1'b1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FAULT  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_UPDATE,
      ST_MUL_NS2,
      ST_MUL_S1S1,
      ST_DIFF,
      ST_ROOT,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [MSTEP_BITS-1:0] steps;
   } mul_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

// ----- rtl/core/bacrms_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module bacrms_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bacrms_pkg::mul_req_type              mul_req,
   input  logic [bacrms_pkg::SQ_BITS-1:0]       mul_a,
   input  logic [bacrms_pkg::SUM_BITS-1:0]      mul_b,
   output bacrms_pkg::mul_sts_type              mul_sts,
   output logic [bacrms_pkg::PROD_BITS-1:0]     mul_product
);
   import bacrms_pkg::*;

   logic [PROD_BITS-1:0]  mcand_ff, mcand_in;
   logic [SUM_BITS-1:0]   mplier_ff, mplier_in;
   logic [PROD_BITS-1:0]  acc_ff, acc_in;
   logic [MSTEP_BITS-1:0] cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (mul_req.start) begin
         mcand_in  = PROD_BITS'(mul_a);
         mplier_in = mul_b;
         acc_in    = '0;
         cnt_in    = mul_req.steps;
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_BITS-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[SUM_BITS-1:1]};
         cnt_in    = cnt_ff - MSTEP_BITS'(1);
         done_in   = (cnt_ff == MSTEP_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign mul_sts.busy = (cnt_ff != '0);
   assign mul_sts.done = done_ff;
   assign mul_product  = acc_ff;

endmodule

// ----- rtl/core/batch_ac_rms_meter.sv -----
// Top level of the batch AC RMS meter: accumulation, serial arithmetic and ports.
//
// Samples arrive on the req stream: tuser marks a fault item, tdata carries the
// channel tag and the millivolt sample. Samples of the selected channel are
// counted, summed and squared; faults mark the current batch as bad.
// When the count reaches the batch length, one item leaves on the rsp stream
// with the rounded AC RMS in tdata and the batch status in tuser.
// A fault item or a sample of another channel needs no arithmetic. A counted
// sample waits on the 12-step bit-serial squaring in the shared multiplier.
// The item that closes a good batch adds 16 and 28 multiplier steps,
// 29 square-root steps and 30 divider steps, all one bit per cycle.
// While a result waits on a stalled receiver in the output register, further
// samples are taken; the block only waits when the next result is ready.
// Reset loads a batch length of 1000 and channel 0, and empties the batch.
// The APB port writes batch_length at address 0 and expected_channel at 4.
module batch_ac_rms_meter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [bacrms_pkg::REQ_DATA_BITS-1:0]    req_tdata,   // channel, sample_mv
   input  logic                                    req_tuser,   // req_type
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [bacrms_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,   // rms_mv, zero fill
   output logic                                    rsp_tuser,   // batch_ok
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [bacrms_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [bacrms_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [bacrms_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                    csr_pready
);
   import bacrms_pkg::*;

   state_type state_ff, state_in;

   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [CH_BITS-1:0]    chan_ff, chan_in;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic                  good_ff, good_in;
   logic [SAMPLE_BITS-1:0] mv_ff, mv_in;

   logic [PROD_BITS-1:0]  p_ff, p_in;
   logic [RAD_BITS-1:0]   rad_ff, rad_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [RDIV_BITS-1:0]  rdiv_ff, rdiv_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RMS_BITS-1:0]   rsp_rms_ff, rsp_rms_in;
   logic                  rsp_ok_ff, rsp_ok_in;

   mul_req_type           mul_req;
   mul_sts_type           mul_sts;
   logic [SQ_BITS-1:0]    mul_a;
   logic [SUM_BITS-1:0]   mul_b;
   logic [PROD_BITS-1:0]  mul_product;

   logic                  req_fire;
   logic                  req_kind;
   logic [CH_BITS-1:0]    req_channel;
   logic [MV_BITS-1:0]    req_sample;
   logic                  take_sample;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  batch_end;
   logic                  rsp_free;
   logic                  csr_write;

   logic [REM_BITS-1:0]   rem_shift, rem_trial;
   logic                  root_bit;
   logic [RDIV_BITS-1:0]  rdiv_shift, divisor;
   logic                  quot_bit;

   assign req_kind    = req_tuser;
   assign req_channel = req_tdata[CH_BITS-1:0];
   assign req_sample  = req_tdata[CH_BITS +: MV_BITS];
   assign req_fire    = req_tvalid && req_tready;
   assign take_sample = req_fire && (req_kind == KIND_SAMPLE) && (req_channel == chan_ff);

   assign count_inc = count_ff + COUNT_BITS'(1);
   assign batch_end = (CMP_BITS'(count_inc) >= CMP_BITS'(len_ff)) || (&count_inc);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   bacrms_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .mul_req     (mul_req),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .mul_sts     (mul_sts),
      .mul_product (mul_product)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_sample) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_sts.done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            priority if (!batch_end) begin
               state_in = ST_IDLE;
            end else if (good_ff) begin
               state_in = ST_MUL_NS2;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MUL_NS2: begin
            if (mul_sts.done) begin
               state_in = ST_MUL_S1S1;
            end
         end
         ST_MUL_S1S1: begin
            if (mul_sts.done) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (step_ff == STEP_BITS'(1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == STEP_BITS'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready    = 1'b0;
      mul_req.start = 1'b0;
      mul_req.steps = MSTEP_BITS'(SAMPLE_BITS);
      mul_a         = SQ_BITS'(mv_in);
      mul_b         = SUM_BITS'(mv_in);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            mul_req.start = take_sample;
         end
         ST_UPDATE: begin
            mul_req.start = batch_end && good_ff;
            mul_req.steps = MSTEP_BITS'(COUNT_BITS);
            mul_a         = sq_in;
            mul_b         = SUM_BITS'(count_in);
         end
         ST_MUL_NS2: begin
            mul_req.start = mul_sts.done;
            mul_req.steps = MSTEP_BITS'(SUM_BITS);
            mul_a         = SQ_BITS'(sum_ff);
            mul_b         = sum_ff;
         end
         default: begin
            mul_req.start = 1'b0;
         end
      endcase
   end

   // Square-root and divider steps.
   always_comb begin
      rem_shift  = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
      rem_trial  = {root_ff, 2'b01};
      root_bit   = (rem_shift >= rem_trial);
      divisor    = RDIV_BITS'({count_ff, 1'b0});
      rdiv_shift = {rdiv_ff[RDIV_BITS-2:0], num_ff[NUM_BITS-1]};
      quot_bit   = (rdiv_shift >= divisor);
   end

   // Datapath next values.
   always_comb begin
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      good_in      = good_ff;
      mv_in        = mv_ff;
      p_in         = p_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      num_in       = num_ff;
      rdiv_in      = rdiv_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rms_in   = rsp_rms_ff;
      rsp_ok_in    = rsp_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mv_in = SAMPLE_BITS'(req_sample);
            if (req_fire && (req_kind == KIND_FAULT)) begin
               good_in = 1'b0;
            end
         end
         ST_UPDATE: begin
            count_in = count_inc;
            sum_in   = sum_ff + SUM_BITS'(mv_ff);
            sq_in    = sq_ff + SQ_BITS'(mul_product);
         end
         ST_MUL_NS2: begin
            if (mul_sts.done) begin
               p_in = mul_product;
            end
         end
         ST_DIFF: begin
            if (p_ff >= mul_product) begin
               rad_in = {p_ff - mul_product, 2'b00};
            end else begin
               rad_in = '0;
            end
            rem_in  = '0;
            root_in = '0;
            step_in = STEP_BITS'(ROOT_BITS);
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[RAD_BITS-3:0], 2'b00};
            rem_in  = root_bit ? (rem_shift - rem_trial) : rem_shift;
            root_in = {root_ff[ROOT_BITS-2:0], root_bit};
            step_in = step_ff - STEP_BITS'(1);
         end
         ST_PREP: begin
            num_in  = NUM_BITS'(root_ff) + NUM_BITS'(count_ff);
            rdiv_in = '0;
            step_in = STEP_BITS'(NUM_BITS);
         end
         ST_DIV: begin
            rdiv_in = quot_bit ? (rdiv_shift - divisor) : rdiv_shift;
            num_in  = {num_ff[NUM_BITS-2:0], quot_bit};
            step_in = step_ff - STEP_BITS'(1);
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = good_ff ? RMS_BITS'(num_ff) : '0;
               rsp_ok_in    = good_ff;
               count_in     = '0;
               sum_in       = '0;
               sq_in        = '0;
               good_in      = 1'b1;
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   // Register file.
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      len_in  = len_ff;
      chan_in = chan_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_BATCH_LENGTH: len_in  = csr_pwdata[LEN_BITS-1:0];
            REG_EXP_CHANNEL:  chan_in = csr_pwdata[CH_BITS-1:0];
            default:          len_in  = len_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_BATCH_LENGTH: csr_prdata = CSR_DATA_BITS'(len_ff);
         REG_EXP_CHANNEL:  csr_prdata = CSR_DATA_BITS'(chan_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         chan_ff      <= CH_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         good_ff      <= 1'b1;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         chan_ff      <= chan_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         good_ff      <= good_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_ff      <= mv_in;
      p_ff       <= p_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      num_ff     <= num_in;
      rdiv_ff    <= rdiv_in;
      rsp_rms_ff <= rsp_rms_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_rms_ff);
   assign rsp_tuser  = rsp_ok_ff;

   // A bad batch always reports zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("bad batch reported a non-zero level");

   // A batch can only close with at least one counted sample.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (count_ff != '0))
      else $error("batch closed with an empty count");

   // The multiplier only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == ST_SQUARE || state_ff == ST_MUL_NS2 ||
                        state_ff == ST_MUL_S1S1))
      else $error("multiplier finished outside a multiply state");

   // The multiplier is idle whenever a new item can be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mul_sts.busy)
      else $error("item taken while the multiplier was busy");

endmodule

// ----- tb/batch_ac_rms_meter_test.sv -----
// Self-checking testbench of the batch AC RMS meter with its own batch predictor.
module batch_ac_rms_meter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bacrms_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [CH_BITS-1:0] channel;
      logic [MV_BITS-1:0] sample_mv;
   } sample_item_type;

   typedef struct packed {
      logic [RMS_BITS-1:0] rms_mv;
      logic                batch_ok;
   } rms_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // channel, sample_mv
   logic                     req_tuser = 1'b0; // req_type
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // rms_mv, zero fill
   logic                     rsp_tuser;        // batch_ok
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   sample_item_type pending_samples[$];
   rms_result_type  expected_rms[$];

   logic [LEN_BITS-1:0] cfg_length = LEN_RESET;
   logic [CH_BITS-1:0]  cfg_channel = CH_RESET;
   logic [15:0]         acc_count = '0;
   logic [27:0]         acc_sum = '0;
   logic [39:0]         acc_square_sum = '0;
   logic                acc_good = 1'b1;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int failures = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int bad_batches = 0;

   batch_ac_rms_meter dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [RMS_BITS-1:0] batch_ac_rms(logic [15:0] n, logic [27:0] s1,
                                                        logic [39:0] s2);
      logic [63:0] prod;
      logic [63:0] square;
      logic [63:0] radicand;
      logic [63:0] root;
      logic [63:0] trial;
      prod = 64'(n) * 64'(s2);
      square = 64'(s1) * 64'(s1);
      radicand = (prod >= square) ? (prod - square) << 2 : 64'd0;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) begin
            root = trial;
         end
      end
      return RMS_BITS'((root + 64'(n)) / (64'd2 * 64'(n)));
   endfunction

   function automatic void accumulate_sample(logic kind, logic [CH_BITS-1:0] channel,
                                             logic [MV_BITS-1:0] mv);
      rms_result_type res;
      if (kind == KIND_FAULT) begin
         acc_good = 1'b0;
      end else if (channel == cfg_channel) begin
         acc_count = acc_count + 16'd1;
         acc_sum = acc_sum + 28'(mv);
         acc_square_sum = acc_square_sum + 40'(mv) * 40'(mv);
         if (acc_count >= cfg_length || acc_count == 16'hFFFF) begin
            res.rms_mv = acc_good ? batch_ac_rms(acc_count, acc_sum, acc_square_sum) : '0;
            res.batch_ok = acc_good;
            expected_rms.push_back(res);
            acc_count = '0;
            acc_sum = '0;
            acc_square_sum = '0;
            acc_good = 1'b1;
         end
      end
   endfunction

   always @(posedge clock) begin
      sample_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_sample(req_tuser, req_tdata[CH_BITS-1:0], req_tdata[CH_BITS +: MV_BITS]);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_item = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_item.kind;
               req_tdata <= {next_item.sample_mv, next_item.channel};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rms_result_type want;
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rms.size() == 0) begin
            $error("unexpected result: rms_mv %0d batch_ok %0b", rsp_tdata[RMS_BITS-1:0],
                   rsp_tuser);
            failures++;
         end else begin
            want = expected_rms.pop_front();
            results_checked++;
            if (!want.batch_ok) begin
               bad_batches++;
            end
            if (rsp_tdata[RMS_BITS-1:0] !== want.rms_mv) begin
               $error("rms_mv: expected %0d, actual %0d", want.rms_mv, rsp_tdata[RMS_BITS-1:0]);
               failures++;
            end
            if (rsp_tuser !== want.batch_ok) begin
               $error("batch_ok: expected %0b, actual %0b", want.batch_ok, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[RSP_DATA_BITS-1:RMS_BITS] !== '0) begin
               $error("zero fill: expected 0, actual %0h", rsp_tdata[RSP_DATA_BITS-1:RMS_BITS]);
               failures++;
            end
         end
      end
   end

   task automatic write_register(logic index, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_BATCH_LENGTH) begin
         cfg_length = value[LEN_BITS-1:0];
      end else begin
         cfg_channel = value[CH_BITS-1:0];
      end
   endtask

   task automatic wait_until_drained();
      while (pending_samples.size() != 0 || req_tvalid || expected_rms.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
         default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
   endtask

   task automatic push_item(logic kind, logic [CH_BITS-1:0] channel, logic [MV_BITS-1:0] mv);
      sample_item_type it;
      it.kind = kind;
      it.channel = channel;
      it.sample_mv = mv;
      pending_samples.push_back(it);
   endtask

   task automatic push_random_items(int count);
      int style;
      int base;
      int roll;
      logic [MV_BITS-1:0] mv;
      style = $urandom_range(3);
      base = $urandom_range(4095);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(15) == 0) begin
            style = $urandom_range(3);
            base = $urandom_range(4095);
         end
         case (style)
            0: mv = MV_BITS'($urandom_range(4095));
            1: mv = $urandom_range(1) ? 12'hFFF : 12'h000;
            2: mv = MV_BITS'(base + $urandom_range(6) - 3);
            default: mv = MV_BITS'($urandom_range(15));
         endcase
         roll = $urandom_range(99);
         if (roll < 3) begin
            push_item(KIND_FAULT, CH_BITS'($urandom_range(15)), MV_BITS'($urandom_range(4095)));
         end else if (roll < 15) begin
            push_item(KIND_SAMPLE, cfg_channel + CH_BITS'($urandom_range(1, 15)), mv);
         end else begin
            push_item(KIND_SAMPLE, cfg_channel, mv);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one batch of 1000 channel-0 samples swinging rail to rail.
      set_idling(3);
      for (int i = 0; i < 1000; i++) begin
         if (i % 50 == 7) begin
            push_item(KIND_SAMPLE, CH_BITS'(1 + i % 15), 12'hABC);
         end
         push_item(KIND_SAMPLE, CH_RESET, (i % 2) ? 12'hFFF : 12'h000);
      end
      wait_until_drained();

      set_idling(0);
      write_register(REG_EXP_CHANNEL, 32'd15);
      write_register(REG_BATCH_LENGTH, 32'd1);
      push_item(KIND_SAMPLE, 4'd15, 12'hFFF);
      push_item(KIND_SAMPLE, 4'd15, 12'h000);
      push_item(KIND_SAMPLE, 4'd0, 12'd1234);
      push_item(KIND_FAULT, 4'd15, 12'hFFF);
      push_item(KIND_SAMPLE, 4'd15, 12'd77);
      push_item(KIND_SAMPLE, 4'd15, 12'd2048);
      wait_until_drained();

      write_register(REG_BATCH_LENGTH, 32'd0);
      push_item(KIND_SAMPLE, 4'd15, 12'hFFF);
      push_item(KIND_SAMPLE, 4'd15, 12'd1);
      push_item(KIND_FAULT, 4'd0, 12'd0);
      push_item(KIND_SAMPLE, 4'd15, 12'd5);
      wait_until_drained();

      write_register(REG_BATCH_LENGTH, 32'd2);
      write_register(REG_EXP_CHANNEL, 32'd0);
      push_item(KIND_SAMPLE, 4'd0, 12'h000);
      push_item(KIND_SAMPLE, 4'd0, 12'hFFF);
      push_item(KIND_SAMPLE, 4'd0, 12'hFFF);
      push_item(KIND_SAMPLE, 4'd0, 12'hFFF);
      push_item(KIND_SAMPLE, 4'd0, 12'd1);
      push_item(KIND_SAMPLE, 4'd0, 12'd2);
      wait_until_drained();

      // A long batch cut short by lowering the length below the count reached.
      write_register(REG_BATCH_LENGTH, 32'd65535);
      push_item(KIND_SAMPLE, 4'd0, 12'd100);
      push_item(KIND_SAMPLE, 4'd0, 12'd200);
      push_item(KIND_SAMPLE, 4'd0, 12'd300);
      push_item(KIND_SAMPLE, 4'd0, 12'd4000);
      wait_until_drained();
      write_register(REG_BATCH_LENGTH, 32'd3);
      push_item(KIND_SAMPLE, 4'd0, 12'd50);
      wait_until_drained();

      for (int phase = 0; phase < 8; phase++) begin
         set_idling(phase % 4);
         case (phase)
            2: write_register(REG_EXP_CHANNEL, 32'd15);
            3: write_register(REG_EXP_CHANNEL, 32'd0);
            default: write_register(REG_EXP_CHANNEL, $urandom_range(15));
         endcase
         case (phase)
            1: write_register(REG_BATCH_LENGTH, 32'd0);
            5: write_register(REG_BATCH_LENGTH, $urandom_range(100, 300));
            default: write_register(REG_BATCH_LENGTH, $urandom_range(1, 24));
         endcase
         push_random_items(125);
         wait_until_drained();
      end

      if (expected_rms.size() != 0) begin
         $error("%0d expected results never arrived", expected_rms.size());
         failures++;
      end
      $display("Run covered %0d accepted items and %0d batch results, %0d of them faulted.",
               items_accepted, results_checked, bad_batches);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
